// ===== design/positional_list_engine_macros.svh =====
// ---------------------------------------------------------------------------
// Positional list engine assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
`define PLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLE_ASSERT_IMPL(label, ante, cons, msg)
`define PLE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// ple_pkg
// Widths, operation and status codes, and cell control word.
// ---------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic                  insert;
    logic                  remove;
    logic                  replace;
    logic [IDX_W-1:0]      pos0;
    logic [DATA_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/ple_cell.sv =====
// ---------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, shifts with its neighbors, drives its
// entry onto the read bus when addressed.
// ---------------------------------------------------------------------------
`default_nettype none

module ple_cell (
  input  wire logic                           clk_i,
  input  wire logic [ple_pkg::IDX_W-1:0]      idx_i,
  input  wire ple_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0] left_i,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0] right_i,
  output logic [ple_pkg::DATA_WIDTH-1:0]      entry_o,
  output logic [ple_pkg::DATA_WIDTH-1:0]      hit_o
);

  logic [ple_pkg::DATA_WIDTH-1:0] entry_q;
  logic [ple_pkg::DATA_WIDTH-1:0] entry_d;
  logic                           at_pos;
  logic                           past_pos;

  assign at_pos   = (idx_i == ctrl_i.pos0);
  assign past_pos = (idx_i > ctrl_i.pos0);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && past_pos) begin
      entry_d = left_i;
    end else if ((ctrl_i.insert || ctrl_i.replace) && at_pos) begin
      entry_d = ctrl_i.value;
    end else if (ctrl_i.remove && (at_pos || past_pos)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = at_pos ? entry_q : '0;

endmodule

`default_nettype wire

// ===== design/positional_list_engine.sv =====
// ---------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to 64 words addressed by one-based position.
//
// Input channel (in_valid_i / in_stall_o): mode_i, position_i, value_i.
// Output channel (out_valid_o / out_stall_i): status_o, data_o, count_o,
// empty_res_o, exactly one result word per input word.
// Entries sit in a row of cells; insert and remove shift every cell at or
// past the position by one place toward its neighbor, all at once.
// The result is registered on acceptance and shown in the next cycle.
// Throughput: one word per cycle; the only limit is the single output
// register, which accepts a new word whenever it is empty or being taken.
// A stalled result holds, and the input is stalled until it moves.
// Reset empties the list (count zero) and drops any pending result; entry
// contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

`include "positional_list_engine_macros.svh"

module positional_list_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ple_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [ple_pkg::POS_W-1:0]      position_i,
  input  wire logic [ple_pkg::DATA_WIDTH-1:0] value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [ple_pkg::STATUS_W-1:0]        status_o,
  output logic [ple_pkg::DATA_WIDTH-1:0]      data_o,
  output logic [ple_pkg::CNT_W-1:0]           count_o,
  output logic                                empty_res_o
);

  localparam int unsigned N  = ple_pkg::CAPACITY;
  localparam int unsigned DW = ple_pkg::DATA_WIDTH;

  logic                          accept;
  logic [ple_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          out_valid_q;
  logic [ple_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [DW-1:0]                 data_q, data_d;
  logic [ple_pkg::CNT_W-1:0]     ocount_q;
  logic                          full;
  logic                          pos_nz;
  logic                          in_range;
  logic                          ins_range;
  logic [ple_pkg::POS_W-1:0]     pos_m1;
  ple_pkg::cell_ctrl_t           ctrl;
  logic [DW-1:0]                 entry [N];
  logic [DW-1:0]                 hit   [N];
  logic [DW-1:0]                 rd_data;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full      = (count_q == ple_pkg::CNT_W'(N));
  assign pos_nz    = (position_i != '0);
  assign in_range  = pos_nz && (ple_pkg::CNT_W'(position_i) <= count_q)
                     && (position_i <= ple_pkg::POS_W'(count_q));
  assign ins_range = pos_nz && (position_i <= ple_pkg::POS_W'(count_q + 1'b1));
  assign pos_m1    = position_i - 1'b1;

  // decode
  always_comb begin
    ctrl       = '0;
    ctrl.pos0  = pos_m1[ple_pkg::IDX_W-1:0];
    ctrl.value = value_i;
    status_d   = ple_pkg::STATUS_OK;
    data_d     = '0;
    count_d    = count_q;
    case (mode_i)
      ple_pkg::MODE_INSERT: begin
        if (full) begin
          status_d = ple_pkg::STATUS_FULL;
        end else if (!ins_range) begin
          status_d = ple_pkg::STATUS_BAD_POS;
        end else begin
          ctrl.insert = accept;
          count_d     = count_q + 1'b1;
        end
      end
      ple_pkg::MODE_REMOVE: begin
        if (!in_range) begin
          status_d = ple_pkg::STATUS_BAD_POS;
        end else begin
          ctrl.remove = accept;
          count_d     = count_q - 1'b1;
        end
      end
      ple_pkg::MODE_READ: begin
        if (!in_range) begin
          status_d = ple_pkg::STATUS_BAD_POS;
        end else begin
          data_d = rd_data;
        end
      end
      ple_pkg::MODE_REPLACE: begin
        if (!in_range) begin
          status_d = ple_pkg::STATUS_BAD_POS;
        end else begin
          data_d       = rd_data;
          ctrl.replace = accept;
        end
      end
      ple_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ple_pkg::STATUS_BAD_POS;
      end
    endcase
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [DW-1:0] left;
    logic [DW-1:0] right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[k-1];
    end
    if (k == N - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entry[k+1];
    end
    ple_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (ple_pkg::IDX_W'(k)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[k]),
      .hit_o   (hit[k])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < N; i++) begin
      rd_data = rd_data | hit[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      data_q   <= data_d;
      ocount_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign count_o     = ocount_q;
  assign empty_res_o = (ocount_q == '0);

  `PLE_ASSERT_IMPL(a_count_cap, 1'b1, count_q <= ple_pkg::CNT_W'(N), "count above capacity")
  `PLE_ASSERT_NEXT(a_clear_empties, accept && (mode_i == ple_pkg::MODE_CLEAR), count_q == '0 && out_valid_o && empty_res_o, "clear left entries")
  `PLE_ASSERT_IMPL(a_full_status, out_valid_o && (status_o == ple_pkg::STATUS_FULL), count_o == ple_pkg::CNT_W'(N), "full refusal below capacity")
  `PLE_ASSERT_IMPL(a_count_match, out_valid_o && !in_stall_o, count_o == count_q, "result count differs from list count")

endmodule

`default_nettype wire
